// ===== rtl/gmfc_pkg.sv =====
package gmfc_pkg;

	localparam int DEF_MAX_REGIONS  = 26;
	localparam int DEF_MAX_COLUMNS  = 256;
	localparam int DEF_COLOUR_COUNT = 4;
	localparam int MAX_ROWS         = 256;

	localparam int LETTER_W = 5;
	localparam int CFG_W    = 9;
	localparam int COLOUR_W = 3;
	localparam int ROW_W    = 8;
	localparam int IDX_W    = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_REGIONS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // accept a map cell
		logic clr_start; // begin the adjacency clearing sweep
		logic srch_init; // reset colours and search index
		logic srch_step; // one search step
		logic emit_init; // start reporting at region 0
		logic emit_next; // advance the reporting region
	} gmfc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic map_end;   // the cell being loaded is the last of the map
		logic clr_done;  // clearing sweep has passed its last entry
		logic srch_ok;   // search has coloured every region
		logic srch_fail; // search must backtrack past region 0
		logic emit_last; // reporting region is the highest one
	} gmfc_sts_t;

endpackage

// ===== rtl/gmfc_ctrl.sv =====
module gmfc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found_ok,
	input  gmfc_pkg::gmfc_sts_t sts,
	output gmfc_pkg::gmfc_cmd_t cmd
);
	import gmfc_pkg::*;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_SRCH  = 6'b000100,
		ST_EMIT  = 6'b001000,
		ST_FAIL  = 6'b010000,
		ST_CLEAR = 6'b100000
	} state_t;

	state_t state_q;
	logic   found_q;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT) || (state_q == ST_FAIL);
	assign found_ok  = found_q;

	// Command decode for the current state.
	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == ST_LOAD) && in_valid;
		cmd.srch_init = (state_q == ST_INIT);
		cmd.srch_step = (state_q == ST_SRCH);
		cmd.emit_init = (state_q == ST_SRCH) && sts.srch_ok;
		cmd.emit_next = (state_q == ST_EMIT) && out_ready;
		cmd.clr_start = out_valid && out_ready && ((state_q == ST_FAIL) || sts.emit_last);
	end

	// Sequencing: load, search, report, then sweep the adjacency store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid && sts.map_end) state_q <= ST_INIT;
				end
				ST_INIT: state_q <= ST_SRCH;
				ST_SRCH: begin
					if (sts.srch_ok) begin
						state_q <= ST_EMIT;
						found_q <= 1'b1;
					end else if (sts.srch_fail) begin
						state_q <= ST_FAIL;
						found_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (out_ready && sts.emit_last) state_q <= ST_CLEAR;
				end
				ST_FAIL: begin
					if (out_ready) state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (sts.clr_done) state_q <= ST_LOAD;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end
endmodule

// ===== rtl/gmfc_dp.sv =====
module gmfc_dp #(
	parameter int MAX_REGIONS  = gmfc_pkg::DEF_MAX_REGIONS,
	parameter int MAX_COLUMNS  = gmfc_pkg::DEF_MAX_COLUMNS,
	parameter int COLOUR_COUNT = gmfc_pkg::DEF_COLOUR_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gmfc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gmfc_pkg::CFG_W-1:0]    cfg_data,
	input  logic [gmfc_pkg::LETTER_W-1:0] cell_letter,
	input  gmfc_pkg::gmfc_cmd_t           cmd,
	output gmfc_pkg::gmfc_sts_t           sts,
	output logic [gmfc_pkg::LETTER_W-1:0] region,
	output logic [gmfc_pkg::COLOUR_W-1:0] colour
);
	import gmfc_pkg::*;

	localparam int RI_W  = $clog2(MAX_REGIONS);
	localparam int SW_W  = $clog2(MAX_REGIONS + 1);
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

	logic [LETTER_W-1:0] regions_q;
	logic [CFG_W-1:0]    rows_q, cols_q;

	logic [LETTER_W-1:0] line_q [MAX_COLUMNS];
	logic [LETTER_W-1:0] left_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [MAX_REGIONS-1:0] adj_q [MAX_REGIONS];
	logic [COLOUR_W-1:0] clr_q [MAX_REGIONS];
	logic [LETTER_W-1:0] idx_q;
	logic [SW_W-1:0]     sweep_q;
	logic [LETTER_W-1:0] emit_q;

	logic [LETTER_W-1:0] n_eff;
	logic [CNT_W-1:0]    cols_eff;
	logic [ROW_W:0]      rows_eff;
	logic [LETTER_W-1:0] up_q;
	logic [COL_W-1:0]    col_next;
	logic                row_end;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_q <= LETTER_W'(26);
			rows_q    <= CFG_W'(1);
			cols_q    <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REGIONS: regions_q <= cfg_data[LETTER_W-1:0];
				REG_ROWS:    rows_q    <= cfg_data;
				REG_COLUMNS: cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped register values.
	always_comb begin
		if (regions_q == '0) n_eff = LETTER_W'(1);
		else if (32'(regions_q) > MAX_REGIONS) n_eff = LETTER_W'(MAX_REGIONS);
		else n_eff = regions_q;
		if (cols_q == '0) cols_eff = CNT_W'(1);
		else if (32'(cols_q) > MAX_COLUMNS) cols_eff = CNT_W'(MAX_COLUMNS);
		else cols_eff = CNT_W'(cols_q);
		if (rows_q == '0) rows_eff = (ROW_W+1)'(1);
		else if (32'(rows_q) > MAX_ROWS) rows_eff = (ROW_W+1)'(MAX_ROWS);
		else rows_eff = rows_q;
	end

	assign row_end  = (CNT_W'(col_q) + CNT_W'(1)) >= cols_eff;
	assign col_next = row_end ? '0 : col_q + COL_W'(1);
	assign sts.map_end = row_end && ((ROW_W+1)'(row_q) + (ROW_W+1)'(1) >= rows_eff);

	// Line buffer: store the cell and fetch the letter above the next position.
	// With a single column the next position is the one being written.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q[col_q] <= cell_letter;
			up_q <= (col_next == col_q) ? cell_letter : line_q[col_next];
		end
	end

	// Raster position and left neighbour.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cmd.clr_start) begin
			left_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cmd.load) begin
			left_q <= cell_letter;
			if (row_end) begin
				col_q <= '0;
				row_q <= sts.map_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Adjacency marking and the clearing sweep.
	logic mark_l, mark_u;
	logic [MAX_REGIONS-1:0] cell_bit, left_bit, up_bit;
	assign mark_l = (col_q != '0) && (left_q != cell_letter) && (left_q < n_eff)
		&& (cell_letter < n_eff);
	assign mark_u = (row_q != '0) && (up_q != cell_letter) && (up_q < n_eff)
		&& (cell_letter < n_eff);
	assign cell_bit = MAX_REGIONS'(1) << cell_letter;
	assign left_bit = MAX_REGIONS'(1) << left_q;
	assign up_bit   = MAX_REGIONS'(1) << up_q;
	assign sts.clr_done = (32'(sweep_q) == MAX_REGIONS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr_start) begin
			sweep_q <= '0;
		end else if (!sts.clr_done) begin
			sweep_q <= sweep_q + SW_W'(1);
		end else begin
			sweep_q <= sweep_q;
		end
	end

	// The sweep always runs after reset and after each map before loading.
	logic sweeping;
	assign sweeping = !cmd.load && !cmd.srch_step && !cmd.srch_init;

	always_ff @(posedge clk) begin
		for (int r = 0; r < MAX_REGIONS; r++) begin
			if (cmd.clr_start || (sweeping && sweep_q == SW_W'(r) && !sts.clr_done)) begin
				adj_q[r] <= '0;
			end else if (cmd.load) begin
				adj_q[r] <= adj_q[r]
					| ((mark_l && left_q == LETTER_W'(r)) ? cell_bit : '0)
					| ((mark_u && up_q == LETTER_W'(r)) ? cell_bit : '0)
					| ((mark_l && cell_letter == LETTER_W'(r)) ? left_bit : '0)
					| ((mark_u && cell_letter == LETTER_W'(r)) ? up_bit : '0);
			end
		end
	end

	// One search step: try colours above the current one, lowest first.
	logic [RI_W-1:0]     cur;
	logic [COLOUR_W-1:0] chosen;
	logic [COLOUR_COUNT:1] blocked;
	assign cur = idx_q[RI_W-1:0];

	always_comb begin
		blocked = '0;
		for (int j = 0; j < MAX_REGIONS; j++) begin
			for (int c = 1; c <= COLOUR_COUNT; c++) begin
				if (LETTER_W'(j) < idx_q && adj_q[cur][j] && clr_q[j] == COLOUR_W'(c))
					blocked[c] = 1'b1;
			end
		end
		chosen = '0;
		for (int c = COLOUR_COUNT; c >= 1; c--) begin
			if (COLOUR_W'(c) > clr_q[cur] && !blocked[c]) chosen = COLOUR_W'(c);
		end
	end

	assign sts.srch_ok   = (idx_q >= n_eff);
	assign sts.srch_fail = !sts.srch_ok && (chosen == '0) && (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int r = 0; r < MAX_REGIONS; r++) clr_q[r] <= '0;
		end else if (cmd.srch_init) begin
			idx_q <= '0;
			for (int r = 0; r < MAX_REGIONS; r++) clr_q[r] <= '0;
		end else if (cmd.srch_step && !sts.srch_ok && !sts.srch_fail) begin
			clr_q[cur] <= chosen;
			idx_q <= (chosen != '0) ? idx_q + LETTER_W'(1) : idx_q - LETTER_W'(1);
		end
	end

	// Result reporting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_q <= '0;
		else if (cmd.emit_init) emit_q <= '0;
		else if (cmd.emit_next && !sts.emit_last) emit_q <= emit_q + LETTER_W'(1);
	end

	assign sts.emit_last = (emit_q + LETTER_W'(1) >= n_eff);
	assign region = sts.srch_ok ? emit_q : '0;
	assign colour = sts.srch_ok ? clr_q[emit_q[RI_W-1:0]] : '0;
endmodule

// ===== rtl/grid_map_four_coloring.sv =====
// Grid map colouring: cells enter one item per cycle in raster order while
// in_ready is high; after the last cell the block runs a backtracking search,
// one region step per cycle (each step is a colour choice or a backtrack, so the
// run time follows the shape of the map), then gives one result item per region,
// or a single item with found low when no colouring exists. After each map and
// after reset a sweep clears the adjacency store before the next cell is taken.
module grid_map_four_coloring #(
	parameter int MAX_REGIONS  = gmfc_pkg::DEF_MAX_REGIONS,
	parameter int MAX_COLUMNS  = gmfc_pkg::DEF_MAX_COLUMNS,
	parameter int COLOUR_COUNT = gmfc_pkg::DEF_COLOUR_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gmfc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [gmfc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gmfc_pkg::LETTER_W-1:0] cell_letter,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gmfc_pkg::LETTER_W-1:0] region,
	output logic [gmfc_pkg::COLOUR_W-1:0] colour,
	output logic                          found,
	output logic                          last_result
);
	import gmfc_pkg::*;

	gmfc_cmd_t cmd;
	gmfc_sts_t sts;
	logic      found_ok;

	gmfc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .found_ok(found_ok),
		.sts(sts), .cmd(cmd)
	);

	gmfc_dp #(
		.MAX_REGIONS(MAX_REGIONS), .MAX_COLUMNS(MAX_COLUMNS),
		.COLOUR_COUNT(COLOUR_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cell_letter(cell_letter), .cmd(cmd), .sts(sts),
		.region(region), .colour(colour)
	);

	assign found       = found_ok;
	assign last_result = !found_ok || sts.emit_last;
endmodule
